### src/rv32i_fetch_decode_unit_macros.svh
// Assertion macros shared by the fetch/decode checker.
`ifndef RV32I_FETCH_DECODE_UNIT_MACROS_SVH
`define RV32I_FETCH_DECODE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RFDU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RFDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### src/rfdu_pkg.sv
// Shared types and item codes for the RV32I fetch/decode unit.
`default_nettype none

package rfdu_pkg;

  // Item kinds on the input channel
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_STEP  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [14:0] word_address;
    logic [31:0] program_word;
    logic        decoder_stall;
    logic        jump_from_decoder;
    logic [31:0] decoder_target;
    logic        jump_from_commit;
    logic [31:0] commit_target;
  } step_t;

  typedef struct packed {
    logic               ready_res;
    logic [5:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        instr_address;
    logic               illegal;
  } decoded_t;

  // Decoder result for one word
  typedef struct packed {
    logic [5:0]  operation;
    logic [31:0] immediate;
    logic        illegal;
    logic        ctl;
  } dec_t;

endpackage

`default_nettype wire

### src/rfdu_decode.sv
// RV32I word decoder: operation code, immediate, illegal and control-flow flags.
`default_nettype none

module rfdu_decode (
  input  logic [31:0]        word,
  output rfdu_pkg::dec_t     dec
);

  localparam logic [31:0] EXIT_WORD = 32'h0ff00513;

  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_FENCE  = 7'b0001111;

  localparam logic [5:0] OP_LUI   = 6'd0;
  localparam logic [5:0] OP_AUIPC = 6'd1;
  localparam logic [5:0] OP_JAL   = 6'd2;
  localparam logic [5:0] OP_JALR  = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_BLT   = 6'd6;
  localparam logic [5:0] OP_BGE   = 6'd7;
  localparam logic [5:0] OP_BLTU  = 6'd8;
  localparam logic [5:0] OP_BGEU  = 6'd9;
  localparam logic [5:0] OP_LB    = 6'd10;
  localparam logic [5:0] OP_LH    = 6'd11;
  localparam logic [5:0] OP_LW    = 6'd12;
  localparam logic [5:0] OP_LBU   = 6'd13;
  localparam logic [5:0] OP_LHU   = 6'd14;
  localparam logic [5:0] OP_SB    = 6'd15;
  localparam logic [5:0] OP_SH    = 6'd16;
  localparam logic [5:0] OP_SW    = 6'd17;
  localparam logic [5:0] OP_ADDI  = 6'd18;
  localparam logic [5:0] OP_SLTI  = 6'd19;
  localparam logic [5:0] OP_SLTIU = 6'd20;
  localparam logic [5:0] OP_XORI  = 6'd21;
  localparam logic [5:0] OP_ORI   = 6'd22;
  localparam logic [5:0] OP_ANDI  = 6'd23;
  localparam logic [5:0] OP_SLLI  = 6'd24;
  localparam logic [5:0] OP_SRLI  = 6'd25;
  localparam logic [5:0] OP_SRAI  = 6'd26;
  localparam logic [5:0] OP_ADD   = 6'd27;
  localparam logic [5:0] OP_SUB   = 6'd28;
  localparam logic [5:0] OP_SLL   = 6'd29;
  localparam logic [5:0] OP_SLT   = 6'd30;
  localparam logic [5:0] OP_SLTU  = 6'd31;
  localparam logic [5:0] OP_XOR   = 6'd32;
  localparam logic [5:0] OP_SRL   = 6'd33;
  localparam logic [5:0] OP_SRA   = 6'd34;
  localparam logic [5:0] OP_OR    = 6'd35;
  localparam logic [5:0] OP_AND   = 6'd36;
  localparam logic [5:0] OP_EXIT  = 6'd37;

  logic [6:0] opc;
  logic [2:0] f3;
  logic       b30;
  logic [5:0] op;
  logic       bad;
  logic       ctl;

  assign opc = word[6:0];
  assign f3  = word[14:12];
  assign b30 = word[30];

  always_comb begin
    // Immediate by format
    case (opc)
      OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_FENCE:
        dec.immediate = {{20{word[31]}}, word[31:20]};
      OPC_STORE:
        dec.immediate = {{20{word[31]}}, word[31:25], word[11:7]};
      OPC_BRANCH:
        dec.immediate = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
      OPC_LUI, OPC_AUIPC:
        dec.immediate = {word[31:12], 12'b0};
      OPC_JAL:
        dec.immediate = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
      default:
        dec.immediate = 32'd0;
    endcase

    // Operation code
    op  = OP_LUI;
    bad = 1'b0;
    ctl = 1'b0;
    if (word == EXIT_WORD) begin
      op = OP_EXIT;
    end else begin
      case (opc)
        OPC_LUI:   op = OP_LUI;
        OPC_AUIPC: op = OP_AUIPC;
        OPC_JAL: begin
          op  = OP_JAL;
          ctl = 1'b1;
        end
        OPC_JALR: begin
          op  = OP_JALR;
          ctl = 1'b1;
        end
        OPC_BRANCH: begin
          ctl = 1'b1;
          case (f3)
            3'd0: op = OP_BEQ;
            3'd1: op = OP_BNE;
            3'd4: op = OP_BLT;
            3'd5: op = OP_BGE;
            3'd6: op = OP_BLTU;
            3'd7: op = OP_BGEU;
            default: bad = 1'b1;
          endcase
        end
        OPC_LOAD: begin
          case (f3)
            3'd0: op = OP_LB;
            3'd1: op = OP_LH;
            3'd2: op = OP_LW;
            3'd4: op = OP_LBU;
            3'd5: op = OP_LHU;
            default: bad = 1'b1;
          endcase
        end
        OPC_STORE: begin
          case (f3)
            3'd0: op = OP_SB;
            3'd1: op = OP_SH;
            3'd2: op = OP_SW;
            default: bad = 1'b1;
          endcase
        end
        OPC_OPIMM: begin
          case (f3)
            3'd0: op = OP_ADDI;
            3'd1: op = OP_SLLI;
            3'd2: op = OP_SLTI;
            3'd3: op = OP_SLTIU;
            3'd4: op = OP_XORI;
            3'd5: op = b30 ? OP_SRAI : OP_SRLI;
            3'd6: op = OP_ORI;
            default: op = OP_ANDI;
          endcase
        end
        OPC_OP: begin
          case (f3)
            3'd0: op = b30 ? OP_SUB : OP_ADD;
            3'd1: op = OP_SLL;
            3'd2: op = OP_SLT;
            3'd3: op = OP_SLTU;
            3'd4: op = OP_XOR;
            3'd5: op = b30 ? OP_SRA : OP_SRL;
            3'd6: op = OP_OR;
            default: op = OP_AND;
          endcase
        end
        default: bad = 1'b1;
      endcase
    end
    // illegal words report operation 0 and never hold off fetch
    dec.operation = bad ? OP_LUI : op;
    dec.illegal   = bad;
    dec.ctl       = ctl && !bad;
  end

endmodule

`default_nettype wire

### src/rv32i_fetch_decode_unit.sv
// Top level of the RV32I fetch/decode unit: program store, fetch control, output register.
// Result path: a step item's store read is registered as it is accepted, then decoded into
//   the output register when the read stage advances; write items give no result.
// Throughput: one item per cycle unless the output stalls, bounded by the one-port store.
// Reset: rst clears PC, control wait, held outputs and valids; the store is not cleared.
`default_nettype none

module rv32i_fetch_decode_unit #(
  parameter int STORE_WORDS = 32768   // power of two
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_valid,
  output logic                step_stall,
  input  rfdu_pkg::step_t     step,
  output logic                decoded_valid,
  input  logic                decoded_stall,
  output rfdu_pkg::decoded_t  decoded
);

  localparam int AW = $clog2(STORE_WORDS);

  // What a step item does, settled when it is accepted
  typedef enum logic [1:0] {
    K_FETCH,
    K_HOLD,
    K_BUBBLE
  } kind_t;

  // Program store, one port: a write item or a fetch read per cycle
  logic [31:0] mem [STORE_WORDS];
  logic [31:0] rdata;

  // Read stage: the step item waiting on store data
  logic        s1_valid;
  kind_t       s1_kind;
  logic [31:0] s1_addr;

  logic [31:0] pc;
  logic        ctl_wait;

  logic           s1_advance;
  logic           accept;
  logic           is_step;
  logic           wait_now;
  kind_t          kind;
  logic [31:0]    fetch_addr;
  logic           mem_we;
  logic           mem_re;
  rfdu_pkg::dec_t dec;

  rfdu_decode u_dec (
    .word (rdata),
    .dec  (dec)
  );

  always_comb begin
    // The read stage moves into the output register when that is free or being taken.
    s1_advance = s1_valid && (!decoded_valid || !decoded_stall);
    step_stall = s1_valid && !s1_advance;
    accept     = step_valid && !step_stall;
    is_step    = step.opcode == rfdu_pkg::ITEM_STEP;

    // Control wait as it stands after the item in the read stage. A fetch there
    // forwards its freshly read word's control flag straight from the store output.
    wait_now = ctl_wait;
    if (s1_valid) begin
      case (s1_kind)
        K_FETCH:  wait_now = dec.ctl;
        K_BUBBLE: wait_now = 1'b0;
        default:  wait_now = ctl_wait;
      endcase
    end

    // Commit redirect beats decoder stall, which beats the control wait.
    if (step.jump_from_commit) begin
      kind = K_FETCH;
    end else if (step.decoder_stall) begin
      kind = K_HOLD;
    end else if (wait_now) begin
      kind = K_BUBBLE;
    end else begin
      kind = K_FETCH;
    end

    if (step.jump_from_commit) begin
      fetch_addr = step.commit_target;
    end else if (step.jump_from_decoder) begin
      fetch_addr = step.decoder_target;
    end else begin
      fetch_addr = pc;
    end

    mem_we = accept && !is_step;
    mem_re = accept && is_step && (kind == K_FETCH);
  end

  // Store access; fetch reads drop the low two address bits, and upper address bits wrap.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(step.word_address)] <= step.program_word;
    end
    if (mem_re) begin
      rdata <= mem[fetch_addr[AW+1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s1_kind       <= K_HOLD;
      s1_addr       <= '0;
      pc            <= '0;
      ctl_wait      <= 1'b0;
      decoded_valid <= 1'b0;
      decoded       <= '0;
    end else begin
      if (accept && is_step) begin
        s1_valid <= 1'b1;
        s1_kind  <= kind;
        s1_addr  <= fetch_addr;
        // next PC needs only the address, so it is ready for the next item
        if (kind == K_FETCH) begin
          pc <= fetch_addr + 32'd4;
        end
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      // The output register doubles as the held decode state.
      if (s1_advance) begin
        decoded_valid <= 1'b1;
        case (s1_kind)
          K_FETCH: begin
            decoded.ready_res     <= 1'b1;
            decoded.operation     <= dec.operation;
            decoded.dest_reg      <= rdata[11:7];
            decoded.src1_reg      <= rdata[19:15];
            decoded.src2_reg      <= rdata[24:20];
            decoded.immediate     <= dec.immediate;
            decoded.instr_address <= s1_addr;
            decoded.illegal       <= dec.illegal;
            ctl_wait              <= dec.ctl;
          end
          K_BUBBLE: begin
            decoded.ready_res <= 1'b0;
            ctl_wait          <= 1'b0;
          end
          default: begin
            decoded.ready_res <= 1'b1;
          end
        endcase
      end else if (decoded_valid && !decoded_stall) begin
        decoded_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/rfdu_checker.sv
// Port-level checks for the RV32I fetch/decode unit, bound to the top level.
`default_nettype none

`include "rv32i_fetch_decode_unit_macros.svh"

module rfdu_checker (
  input logic               clk,
  input logic               rst,
  input logic               step_valid,
  input logic               step_stall,
  input rfdu_pkg::step_t    step,
  input logic               decoded_valid,
  input logic               decoded_stall,
  input rfdu_pkg::decoded_t decoded
);

  // input backs up only behind a full, stalled output
  `RFDU_ASSERT_NOW(a_stall_cause, step_stall, decoded_valid && decoded_stall)

  // an accepted step item always has a result waiting after its read stage
  `RFDU_ASSERT_NEXT(a_step_result, step_valid && !step_stall && step.opcode == rfdu_pkg::ITEM_STEP, ##1 decoded_valid)

  // a stalled result holds
  `RFDU_ASSERT_NEXT(a_out_hold, decoded_valid && decoded_stall, decoded_valid && $stable(decoded))

endmodule

bind rv32i_fetch_decode_unit rfdu_checker u_rfdu_checker (.*);

`default_nettype wire
